// ===== hdl/cbd_pkg.sv =====
// Shared types and constants for the console CPU bus decoder.
// Standalone package; used by the decode and top-level modules, by the checker and by the bench.
package cbd_pkg;

	// Default work RAM size in bytes
	localparam int RAM_BYTES_DEF = 2048;
	// Address bits that select the mirrored RAM window (0x0000-0x1FFF)
	localparam int RAM_WIN_BITS = 13;

	// Memory map boundaries
	localparam logic [15:0] ADDR_RAM_END  = 16'h1FFF;
	localparam logic [15:0] ADDR_PPU_END  = 16'h3FFF;
	localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;
	localparam logic [15:0] ADDR_APU_END  = 16'h4015;
	localparam logic [15:0] ADDR_PAD0     = 16'h4016;
	localparam logic [15:0] ADDR_PAD1     = 16'h4017;
	localparam logic [15:0] ADDR_CART_BASE = 16'h4020;

	// Shift position loaded by a pad strobe
	localparam logic [2:0] PAD_POS_TOP = 3'd7;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LOAD  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		TGT_RAM      = 3'd0,
		TGT_PPU      = 3'd1,
		TGT_APU      = 3'd2,
		TGT_PAD      = 3'd3,
		TGT_CART     = 3'd4,
		TGT_DMA      = 3'd5,
		TGT_UNMAPPED = 3'd6,
		TGT_LOAD     = 3'd7
	} target_t;

	// Request beat
	typedef struct packed {
		action_t     action;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        pad_select;
		logic [7:0]  pad_buttons;
	} req_t;

	// Response beat
	typedef struct packed {
		logic [7:0]  read_data;
		target_t     target;
		logic [15:0] forward_address;
		logic [7:0]  forward_data;
		logic        forward_is_write;
	} rsp_t;

	// Decoded controls for one access
	typedef struct packed {
		target_t     target;
		logic [15:0] fwd_addr;
		logic [7:0]  fwd_data;
		logic        fwd_wr;
		logic        ram_rd;
		logic        ram_we;
		logic        pad_rd;
		logic        pad_strobe;
		logic        btn_load;
		logic        pad_sel;
	} dec_t;

endpackage

// ===== hdl/cbd_decode.sv =====
// Address and action decode for one bus access.
// Depends on cbd_pkg for the request, target and decode types.
module cbd_decode (
	input  cbd_pkg::req_t item,
	output cbd_pkg::dec_t dec
);

	logic [15:0] addr;

	assign addr = item.address;

	// Map action and address onto a target and the side effects
	always_comb begin
		dec = '0;
		dec.target = cbd_pkg::TGT_UNMAPPED;
		unique case (item.action)
			cbd_pkg::ACT_READ: begin
				if (addr <= cbd_pkg::ADDR_RAM_END) begin
					dec.target = cbd_pkg::TGT_RAM;
					dec.ram_rd = 1'b1;
				end else if (addr <= cbd_pkg::ADDR_PPU_END) begin
					dec.target = cbd_pkg::TGT_PPU;
					dec.fwd_addr = addr;
				end else if (addr <= cbd_pkg::ADDR_APU_END) begin
					dec.target = cbd_pkg::TGT_APU;
					dec.fwd_addr = addr;
				end else if (addr == cbd_pkg::ADDR_PAD0 || addr == cbd_pkg::ADDR_PAD1) begin
					dec.target = cbd_pkg::TGT_PAD;
					dec.pad_rd = 1'b1;
					dec.pad_sel = addr[0];
				end else if (addr >= cbd_pkg::ADDR_CART_BASE) begin
					dec.target = cbd_pkg::TGT_CART;
					dec.fwd_addr = addr;
				end
			end
			cbd_pkg::ACT_WRITE: begin
				if (addr <= cbd_pkg::ADDR_RAM_END) begin
					dec.target = cbd_pkg::TGT_RAM;
					dec.ram_we = 1'b1;
				end else if (addr <= cbd_pkg::ADDR_PPU_END) begin
					dec.target = cbd_pkg::TGT_PPU;
					dec.fwd_wr = 1'b1;
				end else if (addr == cbd_pkg::ADDR_OAM_DMA) begin
					dec.target = cbd_pkg::TGT_DMA;
					dec.fwd_wr = 1'b1;
				end else if (addr <= cbd_pkg::ADDR_APU_END || addr == cbd_pkg::ADDR_PAD1) begin
					dec.target = cbd_pkg::TGT_APU;
					dec.fwd_wr = 1'b1;
				end else if (addr == cbd_pkg::ADDR_PAD0) begin
					dec.target = cbd_pkg::TGT_PAD;
					dec.pad_strobe = ~item.write_data[0];
				end else if (addr >= cbd_pkg::ADDR_CART_BASE) begin
					dec.target = cbd_pkg::TGT_CART;
					dec.fwd_wr = 1'b1;
				end
				// Forwarded writes carry address and byte
				if (dec.fwd_wr) begin
					dec.fwd_addr = addr;
					dec.fwd_data = item.write_data;
				end
			end
			cbd_pkg::ACT_LOAD: begin
				dec.target = cbd_pkg::TGT_LOAD;
				dec.btn_load = 1'b1;
				dec.pad_sel = item.pad_select;
			end
			default: begin
				dec.target = cbd_pkg::TGT_UNMAPPED;
			end
		endcase
	end

endmodule

// ===== hdl/cbd_ram.sv =====
// Work RAM: one write port, one registered read port, zero-fill sweep after reset.
// Standalone; sized by the DEPTH parameter from the top level.
module cbd_ram #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	output logic          busy
);

	logic [7:0]    ram_q [DEPTH];
	logic [7:0]    rd_data_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_data;

	// Sweep every entry to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Steer the write port to the sweep while it runs
	always_comb begin
		mem_we = clr_busy_q | wr_en;
		mem_addr = clr_busy_q ? clr_addr_q : wr_addr;
		mem_data = clr_busy_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ram_q[mem_addr] <= mem_data;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ram_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy = clr_busy_q;

endmodule

// ===== hdl/console_cpu_bus_decoder_core.sv =====
// Top level of the console CPU bus decoder: input stage, decode, pad state, response register.
// Depends on cbd_pkg, cbd_decode and cbd_ram.
//
//   channel | handshake            | beat
//   --------+----------------------+----------------------
//   request | req_valid / req_ready | req (cbd_pkg::req_t)
//   response| rsp_valid / rsp_ready | rsp (cbd_pkg::rsp_t)
//
// One access per clock sustained while responses are taken and the RAM sweep is done;
// each request beat is registered in the input stage, then in the response register.
// After reset release req_ready stays low until the RAM zero-fill sweep
// ends.
// A stalled response holds the input stage; one more request is still taken while the
// input stage is empty.
module console_cpu_bus_decoder_core #(
	parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cbd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cbd_pkg::rsp_t rsp
);

	localparam int Win = cbd_pkg::RAM_WIN_BITS;
	localparam int RamAw = $clog2(RAM_BYTES);
	// Exact reciprocal for the mirror modulo over the RAM window
	localparam int ShiftS = Win + RamAw;
	localparam int Recip = ((2 ** ShiftS) + RAM_BYTES - 1) / RAM_BYTES;
	localparam int QMax = ((2 ** Win) - 1) / RAM_BYTES;
	localparam int QW = (QMax > 0) ? $clog2(QMax + 1) : 1;
	localparam int PW = ShiftS + QW;
	localparam int IdxW = Win + 1;

	logic           s1_valid_q;
	cbd_pkg::req_t  item_s1;
	logic [QW-1:0]  quot_s1;
	logic [PW-1:0]  quot_prod;
	logic [IdxW-1:0] idx_full;
	logic [RamAw-1:0] ram_idx;
	cbd_pkg::dec_t  dec;

	logic           rsp_valid_q;
	cbd_pkg::rsp_t  rsp_q;
	logic           is_ram_q;
	logic [7:0]     ram_rd_data;
	logic           ram_busy;

	logic [2:0]     pad_pos_q [2];
	logic [7:0]     pad_latch_q [2];
	logic [2:0]     pos_sel;
	logic           pad_bit;

	logic           take;
	logic           out_free;
	logic           fire;

	// Handshake: input stage moves when the response register is free
	assign out_free = ~rsp_valid_q | rsp_ready;
	assign fire = s1_valid_q & out_free;
	assign req_ready = ~ram_busy & (~s1_valid_q | out_free);
	assign take = req_valid & req_ready;

	// Quotient of the mirror window by the RAM size
	assign quot_prod = PW'(req.address[Win-1:0]) * PW'(Recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req;
			quot_s1 <= quot_prod[PW-1:ShiftS];
		end
	end

	// Remainder gives the RAM index
	assign idx_full = IdxW'(item_s1.address[Win-1:0]) - (IdxW'(quot_s1) * IdxW'(RAM_BYTES));
	assign ram_idx = idx_full[RamAw-1:0];

	cbd_decode u_decode (
		.item (item_s1),
		.dec  (dec)
	);

	cbd_ram #(
		.DEPTH (RAM_BYTES)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (fire & dec.ram_rd),
		.rd_addr (ram_idx),
		.rd_data (ram_rd_data),
		.wr_en   (fire & dec.ram_we),
		.wr_addr (ram_idx),
		.wr_data (item_s1.write_data),
		.busy    (ram_busy)
	);

	// Pad bit at the current shift position
	assign pos_sel = pad_pos_q[dec.pad_sel];
	assign pad_bit = pad_latch_q[dec.pad_sel][pos_sel];

	// Advance pad shift positions and latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_pos_q[0] <= '0;
			pad_pos_q[1] <= '0;
			pad_latch_q[0] <= '0;
			pad_latch_q[1] <= '0;
		end else if (fire) begin
			if (dec.pad_rd) begin
				pad_pos_q[dec.pad_sel] <= pos_sel - 3'd1;
			end
			if (dec.pad_strobe) begin
				pad_pos_q[0] <= cbd_pkg::PAD_POS_TOP;
				pad_pos_q[1] <= cbd_pkg::PAD_POS_TOP;
			end
			if (dec.btn_load) begin
				pad_latch_q[dec.pad_sel] <= item_s1.pad_buttons;
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.read_data <= {7'd0, dec.pad_rd & pad_bit};
			rsp_q.target <= dec.target;
			rsp_q.forward_address <= dec.fwd_addr;
			rsp_q.forward_data <= dec.fwd_data;
			rsp_q.forward_is_write <= dec.fwd_wr;
			is_ram_q <= dec.ram_rd;
		end
	end

	// Merge registered RAM data into the beat
	always_comb begin
		rsp = rsp_q;
		if (is_ram_q) begin
			rsp.read_data = ram_rd_data;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hdl/cbd_checker.sv =====
// Port-level checks for the console CPU bus decoder, bound to the top level.
// Depends on cbd_pkg for the beat types and target codes.
module cbd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input cbd_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input cbd_pkg::rsp_t rsp
);

	// Waiting request beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while waiting");

	// Stalled response beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Only forwarded targets carry forward fields
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !(rsp.target == cbd_pkg::TGT_PPU || rsp.target == cbd_pkg::TGT_APU ||
		rsp.target == cbd_pkg::TGT_CART || rsp.target == cbd_pkg::TGT_DMA)
		|-> rsp.forward_address == 16'h0000 && rsp.forward_data == 8'h00 &&
		!rsp.forward_is_write)
		else $error("forward fields set on a local access");

	// Read data only from RAM, and one bit from a pad
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target != cbd_pkg::TGT_RAM |-> rsp.read_data[7:1] == 7'd0 &&
		(rsp.target == cbd_pkg::TGT_PAD || !rsp.read_data[0]))
		else $error("read data on a non-local target");

	// DMA trigger is always a write to its port
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target == cbd_pkg::TGT_DMA
		|-> rsp.forward_is_write && rsp.forward_address == cbd_pkg::ADDR_OAM_DMA)
		else $error("malformed DMA request");

endmodule

bind console_cpu_bus_decoder_core cbd_checker u_cbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== dv/testbench.sv =====
// Self-checking bench for console_cpu_bus_decoder_core: random and directed bus accesses.
// A local predictor tracks RAM, pad latches and shift positions. Depends on cbd_pkg.
module testbench;
	import cbd_pkg::*;

	localparam int         RAM_SIZE     = RAM_BYTES_DEF;
	localparam int         RANDOM_ITEMS = 2000;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         MAX_REPORTS  = 10;
	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam logic [15:0] ADDR_GAP_LO = 16'h4018;
	localparam logic [15:0] ADDR_GAP_HI = 16'h401F;

	// Idle percentages per phase: none, sender, receiver, both
	localparam int SEND_IDLE [4] = '{0, 48, 0, 11};
	localparam int RECV_IDLE [4] = '{0, 0, 48, 11};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	// Predictor state
	logic [7:0] ram_image [RAM_SIZE];
	logic [2:0] pad_pos [2];
	logic [7:0] pad_latch [2];
	int         target_hits [8];

	req_t bus_accesses [$];
	rsp_t due_responses [$];
	int   n_total = 0;
	int   n_accepted = 0;
	int   n_checked = 0;
	int   n_mismatch = 0;
	int   cycle_count = 0;

	console_cpu_bus_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int phase_of(int n);
		int p;
		p = (n_total == 0) ? 0 : (n * 4) / n_total;
		return (p > 3) ? 3 : p;
	endfunction

	// Work out the response of one access and advance the local state
	function automatic rsp_t decode_access(req_t r);
		rsp_t       o;
		logic [15:0] a;
		bit         fwd;
		int         idx;
		o = '0;
		o.target = TGT_UNMAPPED;
		a = r.address;
		fwd = 1'b0;
		idx = int'(a & ADDR_RAM_END) % RAM_SIZE;
		case (r.action)
			ACT_READ: begin
				if (a <= ADDR_RAM_END) begin
					o.target = TGT_RAM;
					o.read_data = ram_image[idx];
				end else if (a <= ADDR_PPU_END) begin
					o.target = TGT_PPU;
					fwd = 1'b1;
				end else if (a <= ADDR_APU_END) begin
					o.target = TGT_APU;
					fwd = 1'b1;
				end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
					o.target = TGT_PAD;
					o.read_data = {7'd0, pad_latch[a[0]][pad_pos[a[0]]]};
					// count down, 0 wraps to 7
					pad_pos[a[0]] = pad_pos[a[0]] - 3'd1;
				end else if (a >= ADDR_CART_BASE) begin
					o.target = TGT_CART;
					fwd = 1'b1;
				end
				if (fwd)
					o.forward_address = a;
			end
			ACT_WRITE: begin
				if (a <= ADDR_RAM_END) begin
					o.target = TGT_RAM;
					ram_image[idx] = r.write_data;
				end else if (a <= ADDR_PPU_END) begin
					o.target = TGT_PPU;
					fwd = 1'b1;
				end else if (a == ADDR_OAM_DMA) begin
					o.target = TGT_DMA;
					fwd = 1'b1;
				end else if (a <= ADDR_APU_END || a == ADDR_PAD1) begin
					o.target = TGT_APU;
					fwd = 1'b1;
				end else if (a == ADDR_PAD0) begin
					o.target = TGT_PAD;
					if (!r.write_data[0]) begin
						pad_pos[0] = PAD_POS_TOP;
						pad_pos[1] = PAD_POS_TOP;
					end
				end else if (a >= ADDR_CART_BASE) begin
					o.target = TGT_CART;
					fwd = 1'b1;
				end
				if (fwd) begin
					o.forward_address = a;
					o.forward_data = r.write_data;
					o.forward_is_write = 1'b1;
				end
			end
			ACT_LOAD: begin
				o.target = TGT_LOAD;
				pad_latch[r.pad_select] = r.pad_buttons;
			end
			default: ;
		endcase
		target_hits[o.target]++;
		return o;
	endfunction

	function automatic req_t mk_access(logic [1:0] act, logic [15:0] a, logic [7:0] wd,
			logic sel, logic [7:0] btn);
		req_t r;
		r.action = action_t'(act);
		r.address = a;
		r.write_data = wd;
		r.pad_select = sel;
		r.pad_buttons = btn;
		return r;
	endfunction

	// Queue one access with a random region and action; unused fields carry noise
	task automatic push_random_access();
		int          pick;
		int          act_pick;
		logic [1:0]  act;
		logic [15:0] a;
		pick = $urandom_range(0, 99);
		act_pick = $urandom_range(0, 99);
		if (pick < 40) begin
			a = 16'($urandom_range(0, ADDR_RAM_END));
			// keep most RAM traffic on a few hot bytes so reads see earlier writes
			if (roll(70))
				a[10:4] = 7'd0;
		end else if (pick < 55)
			a = 16'($urandom_range(ADDR_RAM_END + 1, ADDR_PPU_END));
		else if (pick < 70)
			a = 16'($urandom_range(ADDR_PPU_END + 1, ADDR_APU_END));
		else if (pick < 80)
			a = roll(50) ? ADDR_PAD0 : ADDR_PAD1;
		else if (pick < 85)
			a = 16'($urandom_range(ADDR_GAP_LO, ADDR_GAP_HI));
		else
			a = 16'($urandom_range(ADDR_CART_BASE, 16'hFFFF));
		if (act_pick < 48)
			act = ACT_READ;
		else if (act_pick < 90)
			act = ACT_WRITE;
		else if (act_pick < 98)
			act = ACT_LOAD;
		else
			act = ACT_UNUSED;
		bus_accesses.push_back(mk_access(act, a, 8'($urandom), 1'($urandom), 8'($urandom)));
	endtask

	// Queue a pad poll: load buttons, strobe, then shift bits out of both ports
	task automatic push_pad_poll();
		int n_reads;
		n_reads = $urandom_range(6, 12);
		bus_accesses.push_back(mk_access(ACT_LOAD, 16'($urandom), 8'($urandom), 1'b0,
			8'($urandom)));
		bus_accesses.push_back(mk_access(ACT_LOAD, 16'($urandom), 8'($urandom), 1'b1,
			8'($urandom)));
		if (roll(30))
			bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PAD0, 8'($urandom) | 8'h01,
				1'($urandom), 8'($urandom)));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PAD0, 8'($urandom) & 8'hFE,
			1'($urandom), 8'($urandom)));
		repeat (n_reads)
			bus_accesses.push_back(mk_access(ACT_READ, roll(50) ? ADDR_PAD0 : ADDR_PAD1,
				8'($urandom), 1'($urandom), 8'($urandom)));
	endtask

	// Drive request beats from the pending queue; predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				due_responses.push_back(decode_access(req));
				n_accepted <= n_accepted + 1;
			end
			if (!req_valid || req_ready) begin
				if (bus_accesses.size() != 0 && !roll(SEND_IDLE[phase_of(n_accepted)])) begin
					req_valid <= 1'b1;
					req <= bus_accesses.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Check response beats against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_checked++;
				if (due_responses.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS)
						$display("unexpected response beat: rd=%02h tgt=%0d fa=%04h fd=%02h fw=%0b",
							rsp.read_data, rsp.target, rsp.forward_address,
							rsp.forward_data, rsp.forward_is_write);
				end else begin
					want = due_responses.pop_front();
					if (rsp.read_data !== want.read_data || rsp.target !== want.target ||
							rsp.forward_address !== want.forward_address ||
							rsp.forward_data !== want.forward_data ||
							rsp.forward_is_write !== want.forward_is_write) begin
						n_mismatch++;
						if (n_mismatch <= MAX_REPORTS)
							$display("beat %0d mismatch: exp rd=%02h tgt=%0d fa=%04h fd=%02h fw=%0b, got rd=%02h tgt=%0d fa=%04h fd=%02h fw=%0b",
								n_checked, want.read_data, want.target, want.forward_address,
								want.forward_data, want.forward_is_write, rsp.read_data,
								rsp.target, rsp.forward_address, rsp.forward_data,
								rsp.forward_is_write);
					end
				end
			end
			rsp_ready <= !roll(RECV_IDLE[phase_of(n_accepted)]);
		end
	end

	initial begin
		for (int i = 0; i < RAM_SIZE; i++)
			ram_image[i] = 8'd0;
		pad_pos = '{3'd0, 3'd0};
		pad_latch = '{8'd0, 8'd0};
		foreach (target_hits[i])
			target_hits[i] = 0;

		// Directed: region edges, mirroring, pad shifting and strobe, gap, unused action
		bus_accesses.push_back(mk_access(ACT_READ, 16'h0000, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, 16'h0000, 8'hFF, 1'b1, 8'hFF));
		bus_accesses.push_back(mk_access(ACT_READ, 16'h1800, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, 16'h07FF, 8'h5A, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_RAM_END, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_RAM_END + 1, 8'hFF, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PPU_END, 8'hA5, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PPU_END + 1, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_APU_END, 8'h0F, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_OAM_DMA, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_OAM_DMA, 8'h02, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PAD1, 8'h40, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_LOAD, 16'h0000, 8'h00, 1'b0, 8'hB5));
		bus_accesses.push_back(mk_access(ACT_LOAD, 16'hFFFF, 8'h00, 1'b1, 8'h4C));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PAD0, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PAD0, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PAD1, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PAD0, 8'h01, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PAD1, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_PAD0, 8'hFE, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_PAD1, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_GAP_LO, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, ADDR_GAP_HI, 8'hFF, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_READ, ADDR_CART_BASE, 8'h00, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_WRITE, 16'hFFFF, 8'hFF, 1'b0, 8'h00));
		bus_accesses.push_back(mk_access(ACT_UNUSED, 16'h0000, 8'h77, 1'b1, 8'hFF));

		// Random: single accesses mixed with pad polls
		while (bus_accesses.size() < 26 + RANDOM_ITEMS) begin
			if (roll(8))
				push_pad_poll();
			else
				push_random_access();
		end
		n_total = bus_accesses.size();

		// Hold reset, then release at a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while ((n_accepted != n_total || due_responses.size() != 0) &&
				cycle_count < CYCLE_LIMIT)
			@(posedge clk);

		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles: %0d of %0d accesses accepted, %0d responses due",
				cycle_count, n_accepted, n_total, due_responses.size());
			$display("== FAIL ==");
		end else begin
			// Let any stray response show up
			repeat (8) @(posedge clk);
			if (due_responses.size() != 0) begin
				n_mismatch += due_responses.size();
				$display("%0d responses never arrived", due_responses.size());
			end
			$display("%0d accesses, %0d responses checked, %0d mismatches",
				n_total, n_checked, n_mismatch);
			$display("targets hit: ram %0d ppu %0d apu %0d pad %0d cart %0d dma %0d gap %0d load %0d",
				target_hits[TGT_RAM], target_hits[TGT_PPU], target_hits[TGT_APU],
				target_hits[TGT_PAD], target_hits[TGT_CART], target_hits[TGT_DMA],
				target_hits[TGT_UNMAPPED], target_hits[TGT_LOAD]);
			if (n_mismatch == 0)
				$display("== PASS ==");
			else
				$display("== FAIL ==");
		end
		$finish;
	end

endmodule
